// ===== hw/rtl/stack_language_tokenizer_defines.svh =====
// ---------------------------------------------------------------------------
// Stack language tokenizer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef STACK_LANGUAGE_TOKENIZER_DEFINES_SVH
`define STACK_LANGUAGE_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define SLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");
// next-cycle implication
`define SLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`else
`define SLT_ASSERT_NOW(lbl, ante, cons)
`define SLT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/slt_pkg.sv =====
// ---------------------------------------------------------------------------
// Tokenizer package
// Item types, token kind codes, keyword table and small helper functions.
// ---------------------------------------------------------------------------
package slt_pkg;

  localparam int COUNT_WIDTH       = 32;
  localparam int MAX_COMMENT_DEPTH = 255;
  localparam int DEPTH_W           = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam int NUM_KW            = 21;
  localparam int HEAD_LEN          = 5;

  // result queue; depth must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // token kinds
  localparam logic [4:0] KIND_EOF  = 5'd0;
  localparam logic [4:0] KIND_INT  = 5'd1;
  localparam logic [4:0] KIND_NAME = 5'd2;
  localparam logic [4:0] KIND_SEP0 = 5'd3;
  localparam logic [4:0] KIND_KW0  = 5'd9;
  localparam logic [4:0] KIND_OVF  = 5'd30;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } slt_in_t;

  typedef struct packed {
    logic [4:0]         kind;
    logic [31:0]        start_pos;
    logic [31:0]        start_line;
    logic [31:0]        start_col;
    logic [31:0]        tok_len;
    logic signed [63:0] int_value;
    logic               last_of_run;
  } slt_out_t;

  // first bytes of the current word, entry i is byte i
  typedef logic [HEAD_LEN-1:0][7:0] head_t;

  typedef struct packed {
    logic neg;
    logic dig;
    logic valid;
    logic ovf;
  } num_flags_t;

  // chars[4] is the first byte, unused bytes zero
  typedef struct packed {
    logic [2:0]      len;
    logic [4:0][7:0] chars;
  } kw_entry_t;

  typedef struct packed {
    logic                 emit;
    logic [4:0]           kind;
    logic [63:0]          value;
    logic [DEPTH_W-1:0]   depth_next;
  } slt_close_t;

  typedef struct packed {
    logic [1:0] n;
    slt_out_t   tok0;
    slt_out_t   tok1;
  } slt_push_t;

  typedef struct packed {
    logic                  room2;
    logic [FIFO_CNT_W-1:0] count;
  } slt_fifo_stat_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } sep_hit_t;

  localparam kw_entry_t OPEN_WORD  = '{len: 3'd2, chars: {"/*", 24'h0}};
  localparam kw_entry_t CLOSE_WORD = '{len: 3'd2, chars: {"*/", 24'h0}};

  localparam kw_entry_t KW_TABLE [NUM_KW] = '{
    '{len: 3'd1, chars: {"+",     32'h0}},
    '{len: 3'd1, chars: {"-",     32'h0}},
    '{len: 3'd1, chars: {"*",     32'h0}},
    '{len: 3'd1, chars: {"/",     32'h0}},
    '{len: 3'd1, chars: {"%",     32'h0}},
    '{len: 3'd2, chars: {"==",    24'h0}},
    '{len: 3'd2, chars: {"!=",    24'h0}},
    '{len: 3'd1, chars: {"<",     32'h0}},
    '{len: 3'd1, chars: {">",     32'h0}},
    '{len: 3'd2, chars: {"<=",    24'h0}},
    '{len: 3'd2, chars: {">=",    24'h0}},
    '{len: 3'd1, chars: {"!",     32'h0}},
    '{len: 3'd5, chars: "print"},
    '{len: 3'd2, chars: {"<-",    24'h0}},
    '{len: 3'd2, chars: {"->",    24'h0}},
    '{len: 3'd2, chars: {"if",    24'h0}},
    '{len: 3'd4, chars: {"else",   8'h0}},
    '{len: 3'd5, chars: "while"},
    '{len: 3'd3, chars: {"dup",   16'h0}},
    '{len: 3'd4, chars: {"drop",   8'h0}},
    '{len: 3'd5, chars: "const"}
  };

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [31:0] sat32(logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic word_is(head_t h, logic [COUNT_WIDTH-1:0] len,
                                   kw_entry_t k);
    logic hit;
    hit = (len == COUNT_WIDTH'(k.len));
    for (int i = 0; i < HEAD_LEN; i++) begin
      if (3'(i) < k.len && h[i] != k.chars[3'(HEAD_LEN - 1 - i)]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic sep_hit_t sep_lookup(logic [7:0] c);
    sep_hit_t r;
    r = '{hit: 1'b1, code: 3'd0};
    case (c)
      8'h7B:   r.code = 3'd0;   // {
      8'h7D:   r.code = 3'd1;   // }
      8'h28:   r.code = 3'd2;   // (
      8'h29:   r.code = 3'd3;   // )
      8'h40:   r.code = 3'd4;   // @
      8'h5E:   r.code = 3'd5;   // ^
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/slt_word_close.sv =====
// ---------------------------------------------------------------------------
// Word close logic
// Classifies the pending word and works out the comment depth after it.
// ---------------------------------------------------------------------------
module slt_word_close (
  input  logic [slt_pkg::COUNT_WIDTH-1:0] word_len,
  input  slt_pkg::head_t                  head,
  input  slt_pkg::num_flags_t             flags,
  input  logic [63:0]                     accum,
  input  logic [slt_pkg::DEPTH_W-1:0]     depth,
  output slt_pkg::slt_close_t             info
);

  logic       has_word;
  logic       is_open;
  logic       is_close;
  logic       kw_hit;
  logic [4:0] kw_idx;

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = 0; i < slt_pkg::NUM_KW; i++) begin
      if (!kw_hit && slt_pkg::word_is(head, word_len, slt_pkg::KW_TABLE[i])) begin
        kw_hit = 1'b1;
        kw_idx = 5'(i);
      end
    end
  end

  always_comb begin
    has_word = (word_len != '0);
    is_open  = slt_pkg::word_is(head, word_len, slt_pkg::OPEN_WORD);
    is_close = slt_pkg::word_is(head, word_len, slt_pkg::CLOSE_WORD);

    info.emit       = has_word && (depth == '0) && !is_open;
    info.kind       = slt_pkg::KIND_NAME;
    info.value      = '0;
    info.depth_next = depth;

    if (flags.ovf) begin
      info.kind = slt_pkg::KIND_OVF;
    end else if (flags.valid && flags.dig) begin
      info.kind  = slt_pkg::KIND_INT;
      info.value = flags.neg ? (64'd0 - accum) : accum;
    end else if (kw_hit) begin
      info.kind = slt_pkg::KIND_KW0 + kw_idx;
    end

    if (has_word) begin
      if (depth != '0) begin
        // nested comment: opener counts up (saturating), closer counts down
        if (is_open) begin
          if (depth < slt_pkg::DEPTH_W'(slt_pkg::MAX_COMMENT_DEPTH)) begin
            info.depth_next = depth + slt_pkg::DEPTH_W'(1);
          end
        end else if (is_close) begin
          info.depth_next = depth - slt_pkg::DEPTH_W'(1);
        end
      end else if (is_open) begin
        info.depth_next = slt_pkg::DEPTH_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/slt_core.sv =====
// ---------------------------------------------------------------------------
// Tokenizer core
// Scanner state and per-byte update; builds up to two tokens per item.
// ---------------------------------------------------------------------------
module slt_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  slt_pkg::slt_in_t   item,
  output slt_pkg::slt_push_t push
);

  localparam int CW = slt_pkg::COUNT_WIDTH;

  logic [CW-1:0]                pos, pos_next;
  logic [CW-1:0]                line, line_next;
  logic [CW-1:0]                col, col_next;
  logic [CW-1:0]                wsp, wsp_next;
  logic [CW-1:0]                wsl, wsl_next;
  logic [CW-1:0]                wsc, wsc_next;
  logic [CW-1:0]                word_len, word_len_next;
  slt_pkg::head_t               head, head_next;
  logic [63:0]                  accum, accum_next;
  slt_pkg::num_flags_t          flags, flags_next;
  logic [slt_pkg::DEPTH_W-1:0]  depth, depth_next;
  logic                         ended, ended_next;

  slt_pkg::slt_close_t wi;
  slt_pkg::sep_hit_t   sep;
  slt_pkg::slt_out_t   word_tok, second;
  slt_pkg::num_flags_t fl_b;
  logic [63:0]         acc_b;
  logic [67:0]         prod;
  logic [67:0]         lim;
  logic                at_end, first, digit, sign, close_now, has_second, emit_word;
  logic [1:0]          n;

  slt_word_close u_close (
    .word_len (word_len),
    .head     (head),
    .flags    (flags),
    .accum    (accum),
    .depth    (depth),
    .info     (wi)
  );

  always_comb begin
    pos_next      = pos;
    line_next     = line;
    col_next      = col;
    wsp_next      = wsp;
    wsl_next      = wsl;
    wsc_next      = wsc;
    word_len_next = word_len;
    head_next     = head;
    accum_next    = accum;
    flags_next    = flags;
    depth_next    = depth;
    ended_next    = ended;
    has_second    = 1'b0;
    second        = '0;
    close_now     = 1'b1;

    at_end = item.is_end || (item.ch == slt_pkg::CH_NUL);
    sep    = slt_pkg::sep_lookup(item.ch);
    digit  = (item.ch >= 8'h30) && (item.ch <= 8'h39);
    sign   = (item.ch == slt_pkg::CH_PLUS) || (item.ch == slt_pkg::CH_MINUS);
    first  = (word_len == '0);

    // number tracking for a byte that joins the word
    fl_b  = flags;
    acc_b = accum;
    if (first) begin
      acc_b = '0;
      fl_b  = '0;
      if (sign) begin
        fl_b.valid = 1'b1;
        fl_b.neg   = (item.ch == slt_pkg::CH_MINUS);
      end else if (digit) begin
        fl_b.valid = 1'b1;
      end
    end else if (!digit) begin
      fl_b.valid = 1'b0;
    end
    prod = ({4'b0, acc_b} << 3) + ({4'b0, acc_b} << 1) + 68'(item.ch[3:0]);
    // magnitude limit: 2^63 for a negative word, 2^63 - 1 otherwise
    lim  = fl_b.neg ? {4'b0, 1'b1, 63'b0} : {5'b0, {63{1'b1}}};

    word_tok = '{kind:        wi.kind,
                 start_pos:   slt_pkg::sat32(wsp),
                 start_line:  slt_pkg::sat32(wsl),
                 start_col:   slt_pkg::sat32(wsc),
                 tok_len:     slt_pkg::sat32(word_len),
                 int_value:   wi.value,
                 last_of_run: 1'b0};

    if (ended || at_end) begin
      has_second    = 1'b1;
      second        = '{kind:        slt_pkg::KIND_EOF,
                        start_pos:   slt_pkg::sat32(pos),
                        start_line:  slt_pkg::sat32(line),
                        start_col:   slt_pkg::sat32(col),
                        tok_len:     32'd0,
                        int_value:   64'sd0,
                        last_of_run: 1'b0};
      word_len_next = '0;
      depth_next    = '0;
      ended_next    = 1'b1;
    end else begin
      pos_next = slt_pkg::sat_inc(pos);
      if (item.ch == slt_pkg::CH_LF) begin
        line_next = slt_pkg::sat_inc(line);
        col_next  = CW'(1);
      end else begin
        col_next = slt_pkg::sat_inc(col);
      end

      if (slt_pkg::is_space(item.ch)) begin
        word_len_next = '0;
        depth_next    = wi.depth_next;
      end else if (sep.hit) begin
        word_len_next = '0;
        depth_next    = wi.depth_next;
        if (wi.depth_next == '0) begin
          has_second = 1'b1;
          second     = '{kind:        slt_pkg::KIND_SEP0 + 5'(sep.code),
                         start_pos:   slt_pkg::sat32(pos),
                         start_line:  slt_pkg::sat32(line),
                         start_col:   slt_pkg::sat32(col),
                         tok_len:     32'd1,
                         int_value:   64'sd0,
                         last_of_run: 1'b0};
        end
      end else begin
        close_now = 1'b0;
        if (first) begin
          wsp_next = pos;
          wsl_next = line;
          wsc_next = col;
        end
        flags_next = fl_b;
        accum_next = acc_b;
        if (digit && fl_b.valid && !fl_b.ovf) begin
          flags_next.dig = 1'b1;
          if (prod > lim) begin
            flags_next.ovf = 1'b1;
          end else begin
            accum_next = prod[63:0];
          end
        end
        if (word_len < CW'(slt_pkg::HEAD_LEN)) begin
          head_next[word_len[2:0]] = item.ch;
        end
        word_len_next = slt_pkg::sat_inc(word_len);
      end
    end

    emit_word = wi.emit && close_now;
    n         = {1'b0, emit_word} + {1'b0, has_second};

    push.n                = fire ? n : 2'd0;
    push.tok0             = emit_word ? word_tok : second;
    push.tok0.last_of_run = (n == 2'd1);
    push.tok1             = second;
    push.tok1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      line     <= CW'(1);
      col      <= CW'(1);
      wsp      <= '0;
      wsl      <= CW'(1);
      wsc      <= CW'(1);
      word_len <= '0;
      accum    <= '0;
      flags    <= '0;
      depth    <= '0;
      ended    <= 1'b0;
    end else if (fire) begin
      pos      <= pos_next;
      line     <= line_next;
      col      <= col_next;
      wsp      <= wsp_next;
      wsl      <= wsl_next;
      wsc      <= wsc_next;
      word_len <= word_len_next;
      accum    <= accum_next;
      flags    <= flags_next;
      depth    <= depth_next;
      ended    <= ended_next;
    end
  end

  // word bytes: only entries below word_len are ever read
  always_ff @(posedge clk) begin
    if (fire) begin
      head <= head_next;
    end
  end

endmodule

// ===== hw/rtl/slt_tok_fifo.sv =====
// ---------------------------------------------------------------------------
// Token queue
// Small register queue; takes up to two tokens a cycle, gives one while tok_ready is high.
// ---------------------------------------------------------------------------
module slt_tok_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  slt_pkg::slt_push_t      push,
  output logic                    tok_valid,
  input  logic                    tok_ready,
  output slt_pkg::slt_out_t       tok,
  output slt_pkg::slt_fifo_stat_t stat
);

  localparam int PW = slt_pkg::FIFO_PTR_W;
  localparam int NW = slt_pkg::FIFO_CNT_W;

  slt_pkg::slt_out_t mem [slt_pkg::FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [NW-1:0]     count;
  logic              pop;

  assign tok_valid  = (count != '0);
  assign tok        = mem[rd_ptr];
  assign pop        = tok_valid && tok_ready;
  assign stat.count = count;
  assign stat.room2 = (count <= NW'(slt_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + NW'(push.n) - NW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.tok1;
    end
  end

endmodule

// ===== hw/rtl/stack_language_tokenizer.sv =====
// Flow: an accepted item waits in the input register until the queue has room for two
//   tokens; it is then scanned, and its tokens are queued; the queue head drives tok.
// Throughput: one source byte per cycle while tokens drain; an item that closes a
//   word and emits a separator or end-of-file gives two tokens, one per ready cycle.
// Reset (rst, synchronous): location back to line 1 column 1, no pending word,
//   comment depth zero, token queue empty.
`include "stack_language_tokenizer_defines.svh"
// ---------------------------------------------------------------------------
// Stack language tokenizer
// Streams source bytes in and tokens out, with nested comments and locations.
// ---------------------------------------------------------------------------
module stack_language_tokenizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  slt_pkg::slt_in_t  src,
  output logic              tok_valid,
  input  logic              tok_ready,
  output slt_pkg::slt_out_t tok
);

  // Input register: holds one byte until the core can take it. The core
  // consumes it only when the queue has room for two tokens, the most that
  // a single byte can produce, so no token is ever dropped.
  logic                    stg_valid;
  slt_pkg::slt_in_t        stg_item;
  logic                    stg_fire;
  slt_pkg::slt_push_t      push;
  slt_pkg::slt_fifo_stat_t fstat;

  assign stg_fire  = stg_valid && fstat.room2;
  // new byte is taken whenever the register is empty or is being drained
  assign src_ready = !stg_valid || stg_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (src_ready) begin
      stg_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      stg_item <= src;
    end
  end

  // Scanner: word assembly, number parsing, keyword lookup, comment nesting
  // and location counters all update in the cycle the byte is consumed.
  slt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (stg_fire),
    .item (stg_item),
    .push (push)
  );

  // Token queue decouples the scanner from a stalling consumer.
  slt_tok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .stat      (fstat)
  );

  // queue never holds more than its depth
  `SLT_ASSERT_NOW(a_fifo_bound, 1'b1, fstat.count <= slt_pkg::FIFO_CNT_W'(slt_pkg::FIFO_DEPTH))
  // end-of-file is always the last token of its item
  `SLT_ASSERT_NOW(a_eof_last, tok_valid && tok.kind == slt_pkg::KIND_EOF, tok.last_of_run)
  // only integer tokens carry a value
  `SLT_ASSERT_NOW(a_value_zero, tok_valid && tok.kind != slt_pkg::KIND_INT, tok.int_value == 0)
  // a held byte is not lost while the queue lacks room for two tokens
  `SLT_ASSERT_NEXT(a_stage_hold, stg_valid && !stg_fire, stg_valid)

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// Tokenizer testbench
// Feeds source bytes through the tokenizer under random source gaps and sink
// stalls, predicts every token in step with the input and checks each one.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_BYTES = 660;
  localparam int TAIL_CYCLES  = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              src_valid = 1'b0;
  logic              src_ready;
  slt_pkg::slt_in_t  src = '0;
  logic              tok_valid;
  logic              tok_ready = 1'b0;
  slt_pkg::slt_out_t tok;

  always #5 clk = ~clk;

  stack_language_tokenizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src       (src),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  // character classes and keyword spellings, kind = KIND_KW0 + index
  localparam logic [7:0] WS_BYTES  [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  localparam logic [7:0] SEP_BYTES [6] = '{8'h7B, 8'h7D, 8'h28, 8'h29, 8'h40, 8'h5E};
  string kw_names [slt_pkg::NUM_KW] = '{
    "+", "-", "*", "/", "%", "==", "!=", "<", ">", "<=", ">=", "!",
    "print", "<-", "->", "if", "else", "while", "dup", "drop", "const"
  };

  // -------------------------------------------------------------------------
  // Token predictor: location, pending word and comment depth
  // -------------------------------------------------------------------------
  logic [31:0] loc_pos, loc_line, loc_col;
  logic [31:0] wd_pos, wd_line, wd_col, wd_len;
  logic [7:0]  wd_head [slt_pkg::HEAD_LEN];
  logic [63:0] wd_accum;
  logic        wd_neg, wd_dig, wd_numeric, wd_ovf;
  int unsigned cmt_depth;
  bit          src_done;

  slt_pkg::slt_out_t run_toks [2];     // tokens caused by the byte being predicted
  int                run_n;
  slt_pkg::slt_out_t pending_tokens [$];

  // bookkeeping
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          kind_tally [32];
  longint      cycle_count = 0;
  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  function automatic bit is_white(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int sep_code(logic [7:0] c);
    for (int i = 0; i < 6; i++) begin
      if (SEP_BYTES[i] == c) return i;
    end
    return -1;
  endfunction

  // pending word equals s (head holds at most the first five bytes)
  function automatic bit word_equals(string s);
    if (wd_len != 32'(s.len())) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (wd_head[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_token(logic [4:0] kind, logic [31:0] p, logic [31:0] l,
                                     logic [31:0] c, logic [31:0] len, logic [63:0] v);
    slt_pkg::slt_out_t t;
    t.kind        = kind;
    t.start_pos   = p;
    t.start_line  = l;
    t.start_col   = c;
    t.tok_len     = len;
    t.int_value   = v;
    t.last_of_run = 1'b0;
    run_toks[run_n] = t;
    run_n++;
  endfunction

  function automatic void reset_predictor();
    loc_pos    = '0;
    loc_line   = 32'd1;
    loc_col    = 32'd1;
    wd_pos     = '0;
    wd_line    = 32'd1;
    wd_col     = 32'd1;
    wd_len     = '0;
    wd_accum   = '0;
    wd_neg     = 1'b0;
    wd_dig     = 1'b0;
    wd_numeric = 1'b0;
    wd_ovf     = 1'b0;
    cmt_depth  = 0;
    src_done   = 1'b0;
  endfunction

  function automatic void step_location(logic [7:0] c);
    loc_pos = bump(loc_pos);
    if (c == slt_pkg::CH_LF) begin
      loc_line = bump(loc_line);
      loc_col  = 32'd1;
    end else begin
      loc_col = bump(loc_col);
    end
  endfunction

  // Ends the pending word. Inside a comment only the open/close words matter.
  function automatic void close_word();
    logic [4:0]  kind;
    logic [63:0] val;
    if (wd_len == 0) return;
    if (cmt_depth > 0) begin
      if (word_equals("/*")) begin
        if (cmt_depth < slt_pkg::MAX_COMMENT_DEPTH) cmt_depth++;
      end else if (word_equals("*/")) begin
        cmt_depth--;
      end
      wd_len = '0;
      return;
    end
    if (word_equals("/*")) begin
      cmt_depth = 1;
      wd_len    = '0;
      return;
    end
    kind = slt_pkg::KIND_NAME;
    val  = '0;
    if (wd_ovf) begin
      kind = slt_pkg::KIND_OVF;
    end else if (wd_numeric && wd_dig) begin
      kind = slt_pkg::KIND_INT;
      val  = wd_neg ? -wd_accum : wd_accum;
    end else begin
      for (int i = 0; i < slt_pkg::NUM_KW && kind == slt_pkg::KIND_NAME; i++) begin
        if (word_equals(kw_names[i])) kind = slt_pkg::KIND_KW0 + 5'(i);
      end
    end
    push_token(kind, wd_pos, wd_line, wd_col, wd_len, val);
    wd_len = '0;
  endfunction

  // Appends a word byte; tracks whether the word still reads as an integer.
  function automatic void add_to_word(logic [7:0] c);
    logic        digit;
    logic [63:0] d, lim;
    digit = c >= "0" && c <= "9";
    if (wd_len == 0) begin
      wd_pos     = loc_pos;
      wd_line    = loc_line;
      wd_col     = loc_col;
      wd_accum   = '0;
      wd_neg     = 1'b0;
      wd_dig     = 1'b0;
      wd_numeric = 1'b0;
      wd_ovf     = 1'b0;
      if (c == slt_pkg::CH_PLUS || c == slt_pkg::CH_MINUS) begin
        wd_numeric = 1'b1;
        wd_neg     = (c == slt_pkg::CH_MINUS);
        digit      = 1'b0;
      end else if (digit) begin
        wd_numeric = 1'b1;
      end
    end else if (!digit) begin
      wd_numeric = 1'b0;
    end
    if (digit && wd_numeric && !wd_ovf) begin
      d      = 64'(c - 8'h30);
      lim    = wd_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      wd_dig = 1'b1;
      if (wd_accum > (lim - d) / 64'd10) wd_ovf = 1'b1;
      else wd_accum = wd_accum * 64'd10 + d;
    end
    if (wd_len < slt_pkg::HEAD_LEN) wd_head[wd_len] = c;
    wd_len = bump(wd_len);
  endfunction

  // Advances the predictor by one accepted item and queues its tokens.
  function automatic void tokenize_byte(slt_pkg::slt_in_t it);
    int s;
    run_n = 0;
    s     = sep_code(it.ch);
    if (src_done || it.is_end || it.ch == slt_pkg::CH_NUL) begin
      close_word();
      cmt_depth = 0;
      src_done  = 1'b1;
      push_token(slt_pkg::KIND_EOF, loc_pos, loc_line, loc_col, 32'd0, 64'd0);
    end else if (is_white(it.ch)) begin
      close_word();
      step_location(it.ch);
    end else if (s >= 0) begin
      close_word();
      if (cmt_depth == 0) begin
        push_token(slt_pkg::KIND_SEP0 + 5'(s), loc_pos, loc_line, loc_col, 32'd1, 64'd0);
      end
      step_location(it.ch);
    end else begin
      add_to_word(it.ch);
      step_location(it.ch);
    end
    if (run_n > 0) run_toks[run_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < run_n; i++) pending_tokens.push_back(run_toks[i]);
  endfunction

  // -------------------------------------------------------------------------
  // Source side: one item per call, optional gap, valid held until accepted
  // -------------------------------------------------------------------------
  task automatic feed_item(slt_pkg::slt_in_t it);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid <= 1'b1;
    src       <= it;
    do @(posedge clk); while (!src_ready);
    tokenize_byte(it);
    bytes_sent++;
  endtask

  task automatic feed_byte(logic [7:0] c);
    slt_pkg::slt_in_t it;
    it.ch     = c;
    it.is_end = 1'b0;
    feed_item(it);
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  task automatic feed_space();
    repeat ($urandom_range(1, 2)) feed_byte(WS_BYTES[$urandom_range(0, 5)]);
  endtask

  // -------------------------------------------------------------------------
  // Sink side: random stall before each token
  // -------------------------------------------------------------------------
  initial begin : drain
    int stall;
    forever begin
      @(negedge clk);
      stall = sink_idle ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        tok_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      tok_ready <= 1'b1;
      do @(posedge clk); while (!(tok_valid && !rst));
    end
  end

  // -------------------------------------------------------------------------
  // Token checker: in-order compare against the predicted tokens
  // -------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_tokens
    slt_pkg::slt_out_t want;
    if (!rst && tok_valid && tok_ready) begin
      kind_tally[tok.kind]++;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: kind %0d at pos %0d", tok.kind, tok.start_pos);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind",        64'(want.kind),        64'(tok.kind));
        check_field("start_pos",   64'(want.start_pos),   64'(tok.start_pos));
        check_field("start_line",  64'(want.start_line),  64'(tok.start_line));
        check_field("start_col",   64'(want.start_col),   64'(tok.start_col));
        check_field("tok_len",     64'(want.tok_len),     64'(tok.tok_len));
        check_field("int_value",   want.int_value,        tok.int_value);
        check_field("last_of_run", 64'(want.last_of_run), 64'(tok.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // all six separators, a separator hugging a word, every whitespace byte
  task automatic test_separators();
    feed_text("{}()@^ x(y)");
    for (int i = 0; i < 6; i++) feed_byte(WS_BYTES[i]);
  endtask

  // every keyword, delimited alternately by a separator and by whitespace
  task automatic test_keywords();
    for (int i = 0; i < slt_pkg::NUM_KW; i++) begin
      feed_text(kw_names[i]);
      if (i % 2 == 1) feed_byte(SEP_BYTES[i % 6]);
      else feed_byte(WS_BYTES[i % 6]);
    end
  endtask

  // 64-bit extremes, one past them, signs alone, digits then letters
  task automatic test_integers();
    feed_text("9223372036854775807 -9223372036854775808 ");
    feed_text("9223372036854775808 -9223372036854775809 ");
    feed_text("+0 -7 + - 12a 99999999999999999999zz +x\n");
  endtask

  // keyword prefix in a longer word, stray closer, bytes above 127
  task automatic test_names();
    feed_text("printx */ a_b ");
    feed_byte(8'h80);
    feed_byte(8'hFF);
    feed_byte(8'hC3);
    feed_text("\n");
  endtask

  // nesting, separators and words dropped in comments, closer ending outside
  task automatic test_comments();
    feed_text("/* a ( 5 /* b */ c */ d */ e\n/*(x)*/ f ");
  endtask

  task automatic feed_random_integer();
    int ndig;
    case ($urandom_range(0, 3))
      0: ;
      1: feed_byte(slt_pkg::CH_PLUS);
      default: feed_byte(slt_pkg::CH_MINUS);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      feed_text($urandom_range(0, 1) ? "9223372036854775807" : "9223372036854775808");
    end else begin
      ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 6);
      for (int i = 0; i < ndig; i++) begin
        if (i == 0 && ndig >= 19 && $urandom_range(0, 1)) feed_byte("9");
        else feed_byte(8'h30 + 8'($urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 9) == 0) feed_byte("q");
  endtask

  task automatic feed_random_name();
    string sym;
    int    len;
    sym = "<=>!%_?*";
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: feed_byte(8'h61 + 8'($urandom_range(0, 25)));
        6: feed_byte(8'h41 + 8'($urandom_range(0, 25)));
        7: feed_byte(8'h30 + 8'($urandom_range(0, 9)));
        8: feed_byte(sym[$urandom_range(0, sym.len() - 1)]);
        default: feed_byte(8'($urandom_range(128, 255)));
      endcase
    end
  endtask

  // a well-formed comment, sometimes one level nested, with random content
  task automatic feed_random_comment();
    feed_text("/*");
    feed_space();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) feed_byte(SEP_BYTES[$urandom_range(0, 5)]);
      else feed_random_name();
      feed_space();
    end
    if ($urandom_range(0, 2) == 0) begin
      feed_text("/* ");
      feed_random_name();
      feed_text(" */");
      feed_space();
    end
    feed_text("*/");
  endtask

  // mostly well-formed token streams; a few stray closers and raw bytes
  task automatic test_random_stream();
    int first, mark;
    first = bytes_sent;
    mark  = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      if (bytes_sent - mark >= 64) begin
        mark      = bytes_sent;
        src_idle  = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 99)) inside
        [0:24]:  feed_random_integer();
        [25:44]: begin
          feed_text(kw_names[$urandom_range(0, slt_pkg::NUM_KW - 1)]);
          if ($urandom_range(0, 9) == 0) feed_byte("k");
        end
        [45:59]: feed_random_name();
        [60:69]: feed_byte(SEP_BYTES[$urandom_range(0, 5)]);
        [70:79]: feed_random_comment();
        [80:84]: feed_text("*/");
        default: begin
          repeat ($urandom_range(1, 3)) feed_byte(8'($urandom_range(1, 255)));
          feed_space();
        end
      endcase
      if ($urandom_range(0, 4) != 0) feed_space();
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // End either with a word pending or inside a comment, by NUL or by the end
  // flag; every item after that yields one more end-of-file token.
  task automatic test_end_of_input();
    slt_pkg::slt_in_t it;
    if ($urandom_range(0, 1)) feed_text("/* ab");
    else feed_text(" -42");
    if ($urandom_range(0, 1)) begin
      feed_byte(slt_pkg::CH_NUL);
    end else begin
      it.ch     = 8'($urandom_range(0, 255));
      it.is_end = 1'b1;
      feed_item(it);
    end
    repeat (8) begin
      it.ch     = 8'($urandom_range(0, 255));
      it.is_end = 1'($urandom_range(0, 1));
      feed_item(it);
    end
  endtask

  initial begin
    int n_kw, n_sep;
    foreach (kind_tally[k]) kind_tally[k] = 0;
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_separators();
    test_keywords();
    test_integers();
    test_names();
    test_comments();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    test_random_stream();
    test_end_of_input();

    @(negedge clk);
    src_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    n_kw  = 0;
    n_sep = 0;
    for (int k = slt_pkg::KIND_KW0; k < slt_pkg::KIND_OVF; k++) n_kw += kind_tally[k];
    for (int k = slt_pkg::KIND_SEP0; k < slt_pkg::KIND_KW0; k++) n_sep += kind_tally[k];
    $display("tb: %0d source bytes in, tokens seen: %0d integers, %0d overflows, %0d names,",
             bytes_sent, kind_tally[slt_pkg::KIND_INT], kind_tally[slt_pkg::KIND_OVF],
             kind_tally[slt_pkg::KIND_NAME]);
    $display("tb: %0d keywords, %0d separators, %0d end-of-file", n_kw, n_sep,
             kind_tally[slt_pkg::KIND_EOF]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== stack_language_tokenizer.f =====
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_word_close.sv
hw/rtl/slt_core.sv
hw/rtl/slt_tok_fifo.sv
hw/rtl/stack_language_tokenizer.sv
sim/testbench.sv
